### design/wpp_pkg.sv
package wpp_pkg;

	localparam int MAX_DIGITS   = 7;
	localparam int NAME_LEN_MAX = 255;
	localparam int ACC_W        = 24;
	localparam int DCNT_W       = $clog2(MAX_DIGITS + 1);
	localparam int LEN_W        = $clog2(NAME_LEN_MAX + 1);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam logic [15:0] LEVEL_MAX = 16'hFFFF;
	localparam logic [6:0]  PCT_MAX   = 7'd100;

	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_END      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS = 3'd4;

	localparam logic [15:0] RST_VOLUME   = 16'd100;
	localparam logic [15:0] RST_PITCH    = 16'd100;
	localparam logic [6:0]  RST_START    = 7'd0;
	localparam logic [6:0]  RST_END      = 7'd100;
	localparam logic [6:0]  RST_COMPRESS = 7'd0;

	localparam logic [7:0] CH_OPEN  = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_E     = 8'h65;
	localparam logic [7:0] CH_T     = 8'h74;

	typedef enum logic [1:0] {
		ST_PLAY     = 2'd0,
		ST_DEFAULTS = 2'd1,
		ST_INVALID  = 2'd2
	} wpp_status_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       last_char;
		logic       sentence_begin;
	} wpp_in_t;

	typedef struct packed {
		logic [15:0] volume;
		logic [15:0] pitch;
		logic [6:0]  start_pct;
		logic [6:0]  end_pct;
		logic [6:0]  compress_pct;
	} wpp_params_t;

	typedef struct packed {
		wpp_status_t status;
		logic [7:0]  name_length;
		logic [15:0] volume;
		logic [15:0] pitch;
		logic [6:0]  start_pct;
		logic [6:0]  end_pct;
		logic [6:0]  compress_pct;
	} wpp_out_t;

endpackage

### design/word_param_parser_core.sv
// channel | signals                   | accepted when
// --------+---------------------------+-----------------------------
// in      | in_valid, in_ready, in_item   | in_valid && in_ready
// out     | out_valid, out_ready, out_item | out_valid && out_ready
// cfg     | cfg_we, cfg_index, cfg_data   | cfg_we
//
// one character per cycle while in_ready: an item updates the parse state when accepted
// a result item appears in the cycle after the last character of a token is accepted
// a result waiting in the output register holds off the input until it is taken
// in_ready drops only while a result is held and out_ready is low
// arst_n clears the parse state and loads the register reset values
module word_param_parser_core
	import wpp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  wpp_in_t               in_item,
	output logic                  out_valid,
	input  logic                  out_ready,
	output wpp_out_t              out_item,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	typedef enum logic [2:0] {
		PH_NAME,
		PH_SCAN,
		PH_CMD,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_V,
		CMD_P,
		CMD_S,
		CMD_E,
		CMD_T,
		CMD_CLOSE
	} cmd_t;

	wpp_params_t       cfg_q;
	wpp_params_t       run_defaults_q;
	wpp_params_t       cur_params_q;
	phase_t            phase_q;
	cmd_t              pending_q;
	logic [ACC_W-1:0]  accum_q;
	logic [DCNT_W-1:0] digit_count_q;
	logic [LEN_W-1:0]  name_count_q;
	logic [LEN_W-1:0]  total_count_q;
	logic              close_first_q;
	logic              out_valid_q;
	wpp_out_t          out_q;

	wpp_params_t       rd_eff;
	wpp_params_t       cur_d;
	phase_t            phase_d;
	cmd_t              pending_d;
	logic [ACC_W-1:0]  accum_d;
	logic [DCNT_W-1:0] digit_count_d;
	logic [LEN_W-1:0]  name_count_d;
	logic [LEN_W-1:0]  total_count_d;
	logic              close_first_d;
	logic              is_digit;
	logic [3:0]        digit_val;
	cmd_t              cmd_c;
	logic              accept;
	wpp_out_t          res_d;
	logic              set_defaults;

	function automatic cmd_t command_of(input logic [7:0] c);
		cmd_t r;
		r = CMD_NONE;
		if (c == CH_V) r = CMD_V;
		else if (c == CH_P) r = CMD_P;
		else if (c == CH_S) r = CMD_S;
		else if (c == CH_E) r = CMD_E;
		else if (c == CH_T) r = CMD_T;
		else if (c == CH_CLOSE) r = CMD_CLOSE;
		return r;
	endfunction

	function automatic logic [15:0] clamp_level(input logic [ACC_W-1:0] v);
		return (v > ACC_W'(LEVEL_MAX)) ? LEVEL_MAX : v[15:0];
	endfunction

	function automatic logic [6:0] clamp_pct(input logic [ACC_W-1:0] v);
		return (v > ACC_W'(PCT_MAX)) ? PCT_MAX : v[6:0];
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign is_digit  = (in_item.char_code >= CH_ZERO) && (in_item.char_code <= CH_NINE);
	assign digit_val = in_item.char_code[3:0];
	assign cmd_c     = command_of(in_item.char_code);

	always_comb begin
		rd_eff = run_defaults_q;
		if (in_item.sentence_begin) begin
			rd_eff.volume       = cfg_q.volume;
			rd_eff.pitch        = cfg_q.pitch;
			rd_eff.start_pct    = (cfg_q.start_pct > PCT_MAX) ? PCT_MAX : cfg_q.start_pct;
			rd_eff.end_pct      = (cfg_q.end_pct > PCT_MAX) ? PCT_MAX : cfg_q.end_pct;
			rd_eff.compress_pct = (cfg_q.compress_pct > PCT_MAX) ? PCT_MAX :
				cfg_q.compress_pct;
		end

		cur_d         = cur_params_q;
		phase_d       = phase_q;
		pending_d     = pending_q;
		accum_d       = accum_q;
		digit_count_d = digit_count_q;
		name_count_d  = name_count_q;
		close_first_d = close_first_q;
		total_count_d = (total_count_q < LEN_W'(NAME_LEN_MAX)) ? total_count_q + 1'b1 :
			total_count_q;

		unique case (phase_q)
			PH_NAME: begin
				if (!close_first_q) begin
					if (in_item.char_code == CH_OPEN) begin
						cur_d   = rd_eff;
						phase_d = PH_SCAN;
					end else begin
						if (in_item.char_code == CH_CLOSE) close_first_d = 1'b1;
						if (name_count_q < LEN_W'(NAME_LEN_MAX)) name_count_d = name_count_q + 1'b1;
					end
				end
			end
			PH_SCAN: begin
				if (cmd_c != CMD_NONE) begin
					pending_d = cmd_c;
					phase_d   = PH_CMD;
				end
			end
			PH_CMD: begin
				if (is_digit) begin
					accum_d       = ACC_W'(digit_val);
					digit_count_d = DCNT_W'(1);
					phase_d       = PH_DIGITS;
				end else begin
					phase_d = PH_DONE;
				end
			end
			PH_DIGITS: begin
				if (is_digit && digit_count_q < DCNT_W'(MAX_DIGITS)) begin
					accum_d       = (accum_q << 3) + (accum_q << 1) + ACC_W'(digit_val);
					digit_count_d = digit_count_q + 1'b1;
				end else begin
					unique case (pending_q)
						CMD_V:   cur_d.volume       = clamp_level(accum_q);
						CMD_P:   cur_d.pitch        = clamp_level(accum_q);
						CMD_S:   cur_d.start_pct    = clamp_pct(accum_q);
						CMD_E:   cur_d.end_pct      = clamp_pct(accum_q);
						CMD_T:   cur_d.compress_pct = clamp_pct(accum_q);
						default: ;
					endcase
					accum_d       = '0;
					digit_count_d = '0;
					pending_d     = cmd_c;
					phase_d       = (cmd_c != CMD_NONE) ? PH_CMD : PH_SCAN;
				end
			end
			PH_DONE: ;
			default: ;
		endcase

		set_defaults = 1'b0;
		res_d        = '0;
		if (in_item.char_code != CH_CLOSE) begin
			res_d.status      = ST_PLAY;
			res_d.name_length = (total_count_d > LEN_W'(8'hFF)) ? 8'hFF : 8'(total_count_d);
			{res_d.volume, res_d.pitch, res_d.start_pct, res_d.end_pct,
				res_d.compress_pct} = rd_eff;
		end else if (close_first_d || phase_d == PH_NAME) begin
			res_d.status      = ST_INVALID;
			res_d.name_length = 8'd0;
			{res_d.volume, res_d.pitch, res_d.start_pct, res_d.end_pct,
				res_d.compress_pct} = rd_eff;
		end else if (name_count_d == '0) begin
			set_defaults      = 1'b1;
			res_d.status      = ST_DEFAULTS;
			res_d.name_length = 8'd0;
			{res_d.volume, res_d.pitch, res_d.start_pct, res_d.end_pct,
				res_d.compress_pct} = cur_d;
		end else begin
			res_d.status      = ST_PLAY;
			res_d.name_length = (name_count_d > LEN_W'(8'hFF)) ? 8'hFF : 8'(name_count_d);
			{res_d.volume, res_d.pitch, res_d.start_pct, res_d.end_pct,
				res_d.compress_pct} = cur_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q          <= '{RST_VOLUME, RST_PITCH, RST_START, RST_END, RST_COMPRESS};
			run_defaults_q <= '{RST_VOLUME, RST_PITCH, RST_START, RST_END, RST_COMPRESS};
			cur_params_q   <= '0;
			phase_q        <= PH_NAME;
			pending_q      <= CMD_NONE;
			accum_q        <= '0;
			digit_count_q  <= '0;
			name_count_q   <= '0;
			total_count_q  <= '0;
			close_first_q  <= 1'b0;
			out_valid_q    <= 1'b0;
			out_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_VOLUME:   cfg_q.volume       <= cfg_data;
					CFG_PITCH:    cfg_q.pitch        <= cfg_data;
					CFG_START:    cfg_q.start_pct    <= cfg_data[6:0];
					CFG_END:      cfg_q.end_pct      <= cfg_data[6:0];
					CFG_COMPRESS: cfg_q.compress_pct <= cfg_data[6:0];
					default: ;
				endcase
			end

			if (accept && in_item.last_char) begin
				out_q       <= res_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (accept) begin
				if (in_item.last_char) begin
					run_defaults_q <= set_defaults ? cur_d : rd_eff;
					cur_params_q   <= '0;
					phase_q        <= PH_NAME;
					pending_q      <= CMD_NONE;
					accum_q        <= '0;
					digit_count_q  <= '0;
					name_count_q   <= '0;
					total_count_q  <= '0;
					close_first_q  <= 1'b0;
				end else begin
					run_defaults_q <= rd_eff;
					cur_params_q   <= cur_d;
					phase_q        <= phase_d;
					pending_q      <= pending_d;
					accum_q        <= accum_d;
					digit_count_q  <= digit_count_d;
					name_count_q   <= name_count_d;
					total_count_q  <= total_count_d;
					close_first_q  <= close_first_d;
				end
			end
		end
	end

	a_digit_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= DCNT_W'(MAX_DIGITS))
		else $error("digit count beyond limit");

	a_defaults_pct: assert property (@(posedge clk) disable iff (!arst_n)
		run_defaults_q.start_pct <= PCT_MAX && run_defaults_q.end_pct <= PCT_MAX &&
		run_defaults_q.compress_pct <= PCT_MAX)
		else $error("running default percent out of range");

	a_token_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_item.last_char |=> phase_q == PH_NAME && total_count_q == '0 &&
		name_count_q == '0 && !close_first_q)
		else $error("token state not cleared after last character");

	a_name_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_NAME |-> digit_count_q == '0 && pending_q == CMD_NONE)
		else $error("parse state active while still in name");

	a_result_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(accept && in_item.last_char))
		else $error("result without last character");

	a_result_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != ST_PLAY |-> out_q.name_length == 8'd0)
		else $error("nonzero name length on non-play result");

endmodule
